@@ rtl/bfrs_pkg.sv @@
// Package for the byte frequency rank sorter: operation codes and default sizes.
// No dependencies.
package bfrs_pkg;
    localparam int DefAlphabetSize = 256;
    localparam int DefCountWidth   = 24;
    localparam logic [1:0] FUNC_COUNT = 2'd0;
    localparam logic [1:0] FUNC_SORT  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;
endpackage

@@ rtl/byte_frequency_rank_sorter.sv @@
// Top level of the byte frequency rank sorter: counting table, sort sequencer, rank read.
// Depends on bfrs_pkg.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+----------------------------------------------
//  in      | in_valid  | in_ready  | func, symbol, rank
//  out     | out_valid | out_ready | entry_symbol, entry_count, distinct_symbols,
//          |           |           | entry_valid
//
// Per operation: clear loads its result directly; read reads the entry; count of a new
// symbol reads its position and writes the entry; count of a known symbol reads its
// position, then reads the entry and writes it back. Sort is an insertion sort over the
// table memory, then a rebuild of the position map, both through the one table read port.
// Reset clears the present flags and entry count; memory contents are not reset.
// A finished result waits in the output register; one item is in flight at a time.
module byte_frequency_rank_sorter
    import bfrs_pkg::*;
#(
    parameter int ALPHABET_SIZE = DefAlphabetSize,
    parameter int COUNT_WIDTH   = DefCountWidth
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  symbol,
    input  logic [7:0]  rank,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  entry_symbol,
    output logic [23:0] entry_count,
    output logic [8:0]  distinct_symbols,
    output logic        entry_valid
);
    localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int NW = AW + 1;
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    // states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CRD   = 4'd1;  // count: position read back
    localparam logic [3:0] S_CWR   = 4'd2;  // count: entry read back, write
    localparam logic [3:0] S_RRD   = 4'd3;  // read: entry read back
    localparam logic [3:0] S_OUT   = 4'd4;  // result waiting
    localparam logic [3:0] S_SI    = 4'd5;  // sort: read entry i
    localparam logic [3:0] S_SIW   = 4'd6;  // sort: latch key
    localparam logic [3:0] S_SJ    = 4'd7;  // sort: read entry j-1
    localparam logic [3:0] S_SJW   = 4'd8;  // sort: compare/shift
    localparam logic [3:0] S_SPR   = 4'd9;  // position rebuild: read
    localparam logic [3:0] S_SPW   = 4'd10; // position rebuild: write

    // table memory: symbol, count, arrival
    localparam int EW = 8 + COUNT_WIDTH + AW;
    logic [EW-1:0] tab_mem [ALPHABET_SIZE];
    logic [AW-1:0] pos_mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] present_reg;

    logic [3:0]    state_reg, state_next;
    logic [NW-1:0] used_reg, used_next;
    logic [1:0]    func_reg;
    logic [7:0]    sym_reg;
    logic [7:0]    rank_reg;
    logic [NW-1:0] i_reg, i_next, j_reg, j_next;
    logic [EW-1:0] key_reg;
    logic          zero_ins_reg;

    logic          t_we;
    logic [AW-1:0] t_addr, t_waddr;
    logic [EW-1:0] t_wdata, t_rdata;
    logic          p_we;
    logic [AW-1:0] p_addr, p_waddr, p_wdata, p_rdata;

    always_ff @(posedge clk)
    begin
        if (t_we)
            tab_mem[t_waddr] <= t_wdata;
        t_rdata <= tab_mem[t_addr];
        if (p_we)
            pos_mem[p_waddr] <= p_wdata;
        p_rdata <= pos_mem[p_addr];
    end

    logic [7:0]             rd_sym;
    logic [COUNT_WIDTH-1:0] rd_cnt, key_cnt;
    logic [AW-1:0]          rd_arr, key_arr;
    assign rd_sym  = t_rdata[EW-1 -: 8];
    assign rd_cnt  = t_rdata[AW +: COUNT_WIDTH];
    assign rd_arr  = t_rdata[AW-1:0];
    assign key_cnt = key_reg[AW +: COUNT_WIDTH];
    assign key_arr = key_reg[AW-1:0];

    logic sym_in_range;
    assign sym_in_range = ({1'b0, sym_reg} < 9'(ALPHABET_SIZE));
    logic [AW-1:0] sym_idx;
    assign sym_idx = AW'(sym_reg);

    logic key_before;
    assign key_before = (key_cnt < rd_cnt) || (key_cnt == rd_cnt && key_arr < rd_arr);

    logic                   res_load;
    logic [7:0]             res_sym;
    logic [COUNT_WIDTH-1:0] res_cnt;
    logic                   res_ev;
    logic                   clr_present, set_present;

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        t_we        = 1'b0;
        t_addr      = '0;
        t_waddr     = '0;
        t_wdata     = '0;
        p_we        = 1'b0;
        p_addr      = sym_idx;
        p_waddr     = '0;
        p_wdata     = '0;
        res_load    = 1'b0;
        res_sym     = '0;
        res_cnt     = '0;
        res_ev      = 1'b0;
        clr_present = 1'b0;
        set_present = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (func)
                        FUNC_COUNT: state_next = S_CRD;
                        FUNC_SORT:
                        begin
                            i_next     = NW'(1);
                            state_next = S_SI;
                        end
                        FUNC_READ:  state_next = S_RRD;
                        default:    state_next = S_OUT;
                    endcase
                    t_addr = AW'(rank);
                    // position lookup starts on the incoming symbol
                    p_addr = AW'(symbol);
                end
            end
            S_OUT:
            begin
                if (func_reg == FUNC_CLEAR)
                begin
                    // clear result is loaded once on entry below
                end
                if (out_ready)
                    state_next = S_IDLE;
            end
            S_CRD:
            begin
                if (!sym_in_range)
                begin
                    res_load   = 1'b1;
                    state_next = S_OUT;
                end
                else if (present_reg[sym_idx])
                begin
                    t_addr     = p_rdata;
                    state_next = S_CWR;
                end
                else
                begin
                    if (used_reg < NW'(ALPHABET_SIZE))
                    begin
                        t_we        = 1'b1;
                        t_waddr     = AW'(used_reg);
                        t_wdata     = {sym_reg, COUNT_WIDTH'(1), AW'(used_reg)};
                        p_we        = 1'b1;
                        p_waddr     = sym_idx;
                        p_wdata     = AW'(used_reg);
                        set_present = 1'b1;
                        used_next   = used_reg + NW'(1);
                    end
                    res_load   = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_CWR:
            begin
                t_addr  = p_rdata;
                t_waddr = p_rdata;
                if (rd_cnt != CMAX)
                begin
                    t_we    = 1'b1;
                    t_wdata = {rd_sym, rd_cnt + COUNT_WIDTH'(1), rd_arr};
                end
                res_load   = 1'b1;
                state_next = S_OUT;
            end
            S_RRD:
            begin
                res_load = 1'b1;
                if ({1'b0, rank_reg} < 9'(used_reg))
                begin
                    res_sym = rd_sym;
                    res_cnt = rd_cnt;
                    res_ev  = 1'b1;
                end
                state_next = S_OUT;
            end
            S_SI:
            begin
                if (i_reg >= used_reg)
                begin
                    i_next     = '0;
                    state_next = S_SPR;
                end
                else
                begin
                    t_addr     = AW'(i_reg);
                    j_next     = i_reg;
                    state_next = S_SIW;
                end
            end
            S_SIW:
            begin
                t_addr     = AW'(j_reg - NW'(1));
                state_next = S_SJW;
            end
            S_SJ:
            begin
                t_addr     = AW'(j_reg - NW'(1));
                state_next = S_SJW;
            end
            S_SJW:
            begin
                if (key_before)
                begin
                    t_we    = 1'b1;
                    t_waddr = AW'(j_reg);
                    t_wdata = t_rdata;
                    j_next  = j_reg - NW'(1);
                    if (j_reg == NW'(1))
                    begin
                        // key lands at slot 0 in the following S_SI cycle
                        state_next = S_SI;
                        i_next     = i_reg + NW'(1);
                    end
                    else
                        state_next = S_SJ;
                end
                else
                begin
                    t_we       = 1'b1;
                    t_waddr    = AW'(j_reg);
                    t_wdata    = key_reg;
                    i_next     = i_reg + NW'(1);
                    state_next = S_SI;
                end
            end
            S_SPR:
            begin
                if (i_reg >= used_reg)
                begin
                    res_load   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    t_addr     = AW'(i_reg);
                    state_next = S_SPW;
                end
            end
            S_SPW:
            begin
                p_we       = 1'b1;
                p_waddr    = AW'(rd_sym);
                p_wdata    = AW'(i_reg);
                i_next     = i_reg + NW'(1);
                state_next = S_SPR;
            end
            default: state_next = S_IDLE;
        endcase
        // slot-0 insert after the last shift; S_SI never writes, so the port is free
        if (zero_ins_reg)
        begin
            t_we    = 1'b1;
            t_waddr = '0;
            t_wdata = key_reg;
        end
        if (state_reg == S_IDLE && in_valid && func == FUNC_CLEAR)
        begin
            clr_present = 1'b1;
            used_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            zero_ins_reg <= 1'b0;
        else
            zero_ins_reg <= (state_reg == S_SJW) && key_before && (j_reg == NW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            present_reg <= '0;
            out_valid   <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            if (clr_present)
                present_reg <= '0;
            else if (set_present)
                present_reg[sym_idx] <= 1'b1;
            if (res_load || (state_reg == S_IDLE && in_valid && func == FUNC_CLEAR))
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            func_reg <= func;
            sym_reg  <= symbol;
            rank_reg <= rank;
        end
        if (state_reg == S_SIW)
            key_reg <= t_rdata;
        if (res_load)
        begin
            entry_symbol     <= res_sym;
            entry_count      <= 24'(res_cnt);
            distinct_symbols <= 9'(used_next);
            entry_valid      <= res_ev;
        end
        else if (state_reg == S_IDLE && in_valid && func == FUNC_CLEAR)
        begin
            entry_symbol     <= '0;
            entry_count      <= '0;
            distinct_symbols <= '0;
            entry_valid      <= 1'b0;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
endmodule

@@ rtl/bfrs_checker.sv @@
// Port-level checker for the byte frequency rank sorter, bound to the top level.
// Depends on bfrs_pkg.
module bfrs_checker
    import bfrs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  func,
    input logic        out_valid,
    input logic        out_ready,
    input logic [8:0]  distinct_symbols,
    input logic        entry_valid
);
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("accepted while result pending");
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FUNC_CLEAR |=> out_valid && distinct_symbols == 9'd0)
        else $error("clear result not empty");
    a_ev_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_valid |-> distinct_symbols != 9'd0)
        else $error("valid entry in empty table");
endmodule

bind byte_frequency_rank_sorter bfrs_checker u_bfrs_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .out_valid(out_valid), .out_ready(out_ready), .distinct_symbols(distinct_symbols),
    .entry_valid(entry_valid)
);
